[rtl/core/rszb_pkg.sv]
// rszb_pkg: shared types, register codes and constants for the reverse sensor zone beeper
// no dependencies; imported by every rtl/core module and the checker
`timescale 1ns / 1ps

package rszb_pkg;

	localparam int unsigned TICKS_PER_US_DEF = 3;
	localparam int unsigned CM_DIVISOR       = 58;

	localparam int unsigned STAMP_W    = 16;
	localparam int unsigned DIST_W     = 9;
	localparam int unsigned MS_W       = 16;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [DIST_W-1:0] DIST_MAX = 9'd511;

	typedef enum logic [1:0] {
		ZONE_FAR   = 2'd0,
		ZONE_NEAR  = 2'd1,
		ZONE_VNEAR = 2'd2,
		ZONE_STOP  = 2'd3
	} zone_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FAR_LIMIT   = 3'd0,
		REG_NEAR_LIMIT  = 3'd1,
		REG_VNEAR_LIMIT = 3'd2,
		REG_FAR_BEEP    = 3'd3,
		REG_NEAR_BEEP   = 3'd4,
		REG_VNEAR_BEEP  = 3'd5,
		REG_GAP         = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [DIST_W-1:0] far_limit;
		logic [DIST_W-1:0] near_limit;
		logic [DIST_W-1:0] vnear_limit;
		logic [MS_W-1:0]   far_beep;
		logic [MS_W-1:0]   near_beep;
		logic [MS_W-1:0]   vnear_beep;
		logic [MS_W-1:0]   gap;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		far_limit:   9'd25,
		near_limit:  9'd18,
		vnear_limit: 9'd10,
		far_beep:    16'd500,
		near_beep:   16'd300,
		vnear_beep:  16'd100,
		gap:         16'd100
	};

	typedef struct packed {
		logic blue;
		logic green;
		logic red;
		logic buz;
	} pins_t;

	// led pattern at cycle start, buzzer always on
	function automatic pins_t zone_pins(input zone_t z);
		pins_t p;
		p.buz = 1'b1;
		unique case (z)
			ZONE_FAR: begin
				p.red = 1'b1; p.green = 1'b1; p.blue = 1'b0;
			end
			ZONE_NEAR: begin
				p.red = 1'b1; p.green = 1'b0; p.blue = 1'b1;
			end
			ZONE_VNEAR: begin
				p.red = 1'b0; p.green = 1'b0; p.blue = 1'b1;
			end
			default: begin
				p.red = 1'b0; p.green = 1'b1; p.blue = 1'b1;
			end
		endcase
		return p;
	endfunction

endpackage

[rtl/core/rszb_echo.sv]
// rszb_echo: pairs rising/falling capture edges and converts echo width to centimeters
// depends on rszb_pkg
`timescale 1ns / 1ps

module rszb_echo #(
	parameter int unsigned TICKS_PER_US = rszb_pkg::TICKS_PER_US_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          edge_fire,
	input  logic [rszb_pkg::STAMP_W-1:0]  edge_time,
	output logic [rszb_pkg::DIST_W-1:0]   distance
);
	import rszb_pkg::*;

	// floor(floor(w/T)/58) == floor(w/(58*T)); reciprocal exact for 16-bit w
	localparam int unsigned     DIV     = CM_DIVISOR * TICKS_PER_US;
	localparam int unsigned     SHIFT   = STAMP_W + $clog2(DIV);
	localparam longint unsigned RECIP   = ((64'd1 << SHIFT) + DIV - 1) / DIV;
	localparam int unsigned     RECIP_W = STAMP_W + 2;
	localparam int unsigned     PROD_W  = STAMP_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_C = RECIP[RECIP_W-1:0];

	logic                 expect_rise_q;
	logic [STAMP_W-1:0]   rise_q;
	logic [DIST_W-1:0]    distance_q;

	logic [STAMP_W-1:0]   echo_width;
	logic [PROD_W-1:0]    product;
	logic [PROD_W-1:0]    shifted;
	logic [STAMP_W-1:0]   quot;
	logic [DIST_W-1:0]    dist_new;

	always_comb begin
		echo_width = edge_time - rise_q;
		product    = {{RECIP_W{1'b0}}, echo_width} * {{STAMP_W{1'b0}}, RECIP_C};
		shifted    = product >> SHIFT;
		quot       = shifted[STAMP_W-1:0];
		if (quot > {{(STAMP_W-DIST_W){1'b0}}, DIST_MAX}) begin
			dist_new = DIST_MAX;
		end else begin
			dist_new = quot[DIST_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_rise_q <= 1'b1;
			rise_q        <= '0;
			distance_q    <= '0;
		end else if (edge_fire) begin
			expect_rise_q <= ~expect_rise_q;
			if (expect_rise_q) begin
				rise_q <= edge_time;
			end else begin
				distance_q <= dist_new;
			end
		end
	end

	assign distance = distance_q;

endmodule

[rtl/core/rszb_seq.sv]
// rszb_seq: millisecond tick sequencer, zone classification and pin levels
// depends on rszb_pkg
`timescale 1ns / 1ps

module rszb_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         tick,
	input  rszb_pkg::cfg_t               cfg,
	input  logic [rszb_pkg::DIST_W-1:0]  distance,
	output rszb_pkg::zone_t              zone,
	output rszb_pkg::pins_t              pins
);
	import rszb_pkg::*;

	logic             tone_q;
	logic [MS_W-1:0]  ms_left_q;
	zone_t            zone_q;
	pins_t            pins_q;

	logic             tone_d;
	logic [MS_W-1:0]  ms_left_d;
	logic [MS_W-1:0]  ms_dec;
	zone_t            zone_d;
	zone_t            zone_cls;
	pins_t            pins_d;
	logic [MS_W-1:0]  beep_ms;

	// cascade: far first, then near, then very near
	always_comb begin
		if (distance > cfg.far_limit) begin
			zone_cls = ZONE_FAR;
			beep_ms  = cfg.far_beep;
		end else if (distance > cfg.near_limit) begin
			zone_cls = ZONE_NEAR;
			beep_ms  = cfg.near_beep;
		end else if (distance > cfg.vnear_limit) begin
			zone_cls = ZONE_VNEAR;
			beep_ms  = cfg.vnear_beep;
		end else begin
			zone_cls = ZONE_STOP;
			beep_ms  = cfg.gap;
		end
	end

	always_comb begin
		ms_dec    = (ms_left_q != '0) ? ms_left_q - 1'b1 : '0;
		tone_d    = tone_q;
		ms_left_d = ms_dec;
		zone_d    = zone_q;
		pins_d    = pins_q;
		if (ms_dec == '0) begin
			if (tone_q) begin
				tone_d    = 1'b0;
				ms_left_d = cfg.gap;
				if (zone_q != ZONE_STOP) begin
					pins_d.buz = 1'b0;
				end
			end else begin
				// new cycle; stop zone goes straight into the gap
				zone_d    = zone_cls;
				pins_d    = zone_pins(zone_cls);
				ms_left_d = beep_ms;
				tone_d    = (zone_cls != ZONE_STOP);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_q    <= 1'b0;
			ms_left_q <= '0;
			zone_q    <= ZONE_STOP;
			pins_q    <= '0;
		end else if (tick) begin
			tone_q    <= tone_d;
			ms_left_q <= ms_left_d;
			zone_q    <= zone_d;
			pins_q    <= pins_d;
		end
	end

	assign zone = zone_q;
	assign pins = pins_q;

endmodule

[rtl/core/reverse_sensor_zone_beeper.sv]
// reverse_sensor_zone_beeper: top level with config registers, handshake and result register
// depends on rszb_pkg, rszb_echo, rszb_seq
`timescale 1ns / 1ps

// a result is valid in the cycle after its input transfer
// throughput: one item per cycle while out_ready stays high, a new item is taken while a result is being taken
// the state registers of rszb_echo and rszb_seq are the result register
// reset: asynchronous, clears the echo pairing, distance 0, zone stop, all pins low,
// config registers back to their defaults, no result pending

module reverse_sensor_zone_beeper #(
	parameter int unsigned TICKS_PER_US = rszb_pkg::TICKS_PER_US_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// item channel
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            func,
	input  logic [rszb_pkg::STAMP_W-1:0]    edge_time,
	// result channel
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [rszb_pkg::DIST_W-1:0]     distance_cm,
	output logic [1:0]                      zone,
	output logic                            buzzer_on,
	output logic                            red_pin,
	output logic                            green_pin,
	output logic                            blue_pin,
	// config write port
	input  logic                            cfg_we,
	input  logic [rszb_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [rszb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import rszb_pkg::*;

	cfg_t   cfg_q;
	logic   out_valid_q;
	logic   in_xfer;
	zone_t  zone_cur;
	pins_t  pins_cur;

	// state only moves on a transfer, and a transfer only happens when the
	// result slot is empty or being emptied, so state doubles as the result
	assign in_ready = ~out_valid_q | out_ready;
	assign in_xfer  = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// config registers, unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_FAR_LIMIT:   cfg_q.far_limit   <= cfg_wdata[DIST_W-1:0];
				REG_NEAR_LIMIT:  cfg_q.near_limit  <= cfg_wdata[DIST_W-1:0];
				REG_VNEAR_LIMIT: cfg_q.vnear_limit <= cfg_wdata[DIST_W-1:0];
				REG_FAR_BEEP:    cfg_q.far_beep    <= cfg_wdata[MS_W-1:0];
				REG_NEAR_BEEP:   cfg_q.near_beep   <= cfg_wdata[MS_W-1:0];
				REG_VNEAR_BEEP:  cfg_q.vnear_beep  <= cfg_wdata[MS_W-1:0];
				REG_GAP:         cfg_q.gap         <= cfg_wdata[MS_W-1:0];
				default: ;
			endcase
		end
	end

	// edge transfers feed the echo timer, tick transfers the sequencer
	rszb_echo #(
		.TICKS_PER_US (TICKS_PER_US)
	) u_echo (
		.clk       (clk),
		.arst_n    (arst_n),
		.edge_fire (in_xfer & ~func),
		.edge_time (edge_time),
		.distance  (distance_cm)
	);

	rszb_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (in_xfer & func),
		.cfg      (cfg_q),
		.distance (distance_cm),
		.zone     (zone_cur),
		.pins     (pins_cur)
	);

	assign out_valid = out_valid_q;
	assign zone      = zone_cur;
	assign buzzer_on = pins_cur.buz;
	assign red_pin   = pins_cur.red;
	assign green_pin = pins_cur.green;
	assign blue_pin  = pins_cur.blue;

endmodule

[rtl/core/rszb_checker.sv]
// rszb_checker: port-level assertions for reverse_sensor_zone_beeper, bound to the top level
// depends on rszb_pkg and reverse_sensor_zone_beeper
`timescale 1ns / 1ps

module rszb_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         func,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [rszb_pkg::DIST_W-1:0]  distance_cm,
	input logic [1:0]                   zone,
	input logic                         buzzer_on,
	input logic                         red_pin,
	input logic                         green_pin,
	input logic                         blue_pin
);
	import rszb_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(distance_cm) && $stable(zone)
			&& $stable({buzzer_on, red_pin, green_pin, blue_pin}))
		else $error("result changed while stalled");

	// distance moves only after an edge transfer
	a_dist_on_edge: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_valid && in_ready && !func) |=> $stable(distance_cm))
		else $error("distance changed without an edge transfer");

	// zone moves only after a tick transfer
	a_zone_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_valid && in_ready && func) |=> $stable(zone))
		else $error("zone changed without a tick transfer");

	// once a stop cycle has started the buzzer stays on, with green and blue lit and red off
	a_stop_buzz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zone == ZONE_STOP && (red_pin || green_pin || blue_pin)
			|-> buzzer_on && green_pin && blue_pin && !red_pin)
		else $error("stop zone without buzzer or with wrong leds");

endmodule

bind reverse_sensor_zone_beeper rszb_checker u_rszb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.func        (func),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.distance_cm (distance_cm),
	.zone        (zone),
	.buzzer_on   (buzzer_on),
	.red_pin     (red_pin),
	.green_pin   (green_pin),
	.blue_pin    (blue_pin)
);

[bench/reverse_sensor_zone_beeper_tb.sv]
// reverse_sensor_zone_beeper_tb: self-checking bench for the zone beeper, with a directed table
// followed by randomized register settings, echo pairs, ticks and backpressure on both channels
// depends on rszb_pkg and the reverse_sensor_zone_beeper rtl
`timescale 1ns / 1ps

module reverse_sensor_zone_beeper_tb;
	import rszb_pkg::*;

	localparam int  HALF_PERIOD   = 5;
	localparam int  RESET_CYCLES  = 5;
	localparam int  DRAIN_CYCLES  = 4;        // result shows up in the cycle after its transfer
	localparam int  LONG_HOLD     = 64;       // receiver hold-off that fills the block
	localparam int  NUM_PHASES    = 8;
	localparam int  PHASE_ITEMS   = 205;
	localparam int  CM_PER_WIDTH  = TICKS_PER_US_DEF * CM_DIVISOR;  // timer ticks per cm
	localparam real RUN_LIMIT_NS  = 5_000_000.0;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;   // index past the register list

	// one result item as seen on the output channel
	typedef struct packed {
		logic [DIST_W-1:0] distance;
		zone_t             zone;
		logic              buz;
		logic              red;
		logic              green;
		logic              blue;
	} reading_t;

	localparam reading_t NO_CHECK = '0;

	typedef enum logic [1:0] {
		ROW_EDGE,
		ROW_TICK,
		ROW_WRITE
	} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  addr;
		logic [CFG_DATA_W-1:0] value;     // stamp for items, data for writes
		bit                    typed;     // want holds a hand-written result
		reading_t              want;
	} plan_row_t;

	// dut ports
	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic                  func;
	logic [STAMP_W-1:0]    edge_time;
	logic                  out_valid;
	logic                  out_ready;
	logic [DIST_W-1:0]     distance_cm;
	logic [1:0]            zone;
	logic                  buzzer_on;
	logic                  red_pin;
	logic                  green_pin;
	logic                  blue_pin;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	// predictor state, mirrors the block
	cfg_t              cfg_m;
	bit                want_rise_m;
	logic [STAMP_W-1:0] rise_m;
	logic [DIST_W-1:0] dist_m;
	bit                tone_m;
	logic [MS_W-1:0]   ms_m;
	zone_t             zone_m;
	pins_t             pins_m;

	reading_t pending_readings[$];
	plan_row_t plan[$];

	int  mismatch_count = 0;
	int  readings_seen  = 0;
	int  edges_sent     = 0;
	int  ticks_sent     = 0;
	int  settings_used  = 0;
	int  stall_asked    = 0;   // bumped by the sender, served by the receiver
	bit  idle_on        = 1'b1;

	reverse_sensor_zone_beeper i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.edge_time   (edge_time),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.distance_cm (distance_cm),
		.zone        (zone),
		.buzzer_on   (buzzer_on),
		.red_pin     (red_pin),
		.green_pin   (green_pin),
		.blue_pin    (blue_pin),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata)
	);

	always #HALF_PERIOD clk = ~clk;

	task automatic flag_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// advance the mirrored state by one accepted item and return the result it causes
	task automatic beeper_predict(input logic f, input logic [STAMP_W-1:0] stamp,
			output reading_t r);
		logic [STAMP_W-1:0] width;
		int unsigned        cm;
		if (!f) begin
			if (want_rise_m) begin
				rise_m      = stamp;
				want_rise_m = 1'b0;
			end else begin
				width = stamp - rise_m;   // wraps modulo 2^16
				cm    = (32'(width) / TICKS_PER_US_DEF) / CM_DIVISOR;
				dist_m = (cm > 32'(DIST_MAX)) ? DIST_MAX : cm[DIST_W-1:0];
				want_rise_m = 1'b1;
			end
		end else begin
			if (ms_m != '0)
				ms_m = ms_m - 1'b1;
			if (ms_m == '0) begin
				if (tone_m) begin
					// tone window over, gap begins; stop zone keeps sounding
					tone_m = 1'b0;
					ms_m   = cfg_m.gap;
					if (zone_m != ZONE_STOP)
						pins_m.buz = 1'b0;
				end else if (dist_m > cfg_m.far_limit) begin
					zone_m = ZONE_FAR;
					pins_m = '{blue: 1'b0, green: 1'b1, red: 1'b1, buz: 1'b1};
					ms_m   = cfg_m.far_beep;
					tone_m = 1'b1;
				end else if (dist_m > cfg_m.near_limit) begin
					zone_m = ZONE_NEAR;
					pins_m = '{blue: 1'b1, green: 1'b0, red: 1'b1, buz: 1'b1};
					ms_m   = cfg_m.near_beep;
					tone_m = 1'b1;
				end else if (dist_m > cfg_m.vnear_limit) begin
					zone_m = ZONE_VNEAR;
					pins_m = '{blue: 1'b1, green: 1'b0, red: 1'b0, buz: 1'b1};
					ms_m   = cfg_m.vnear_beep;
					tone_m = 1'b1;
				end else begin
					// stop zone skips the tone window and goes straight to the gap
					zone_m = ZONE_STOP;
					pins_m = '{blue: 1'b1, green: 1'b1, red: 1'b0, buz: 1'b1};
					ms_m   = cfg_m.gap;
					tone_m = 1'b0;
				end
			end
		end
		r = '{dist_m, zone_m, pins_m.buz, pins_m.red, pins_m.green, pins_m.blue};
	endtask

	// offer one item, optionally after a sender idle burst; returns at the transfer edge
	task automatic push_item(input logic f, input logic [STAMP_W-1:0] stamp,
			input bit typed, input reading_t want);
		reading_t r;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		func      <= f;
		edge_time <= stamp;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		// transfer happened at this edge
		beeper_predict(f, stamp, r);
		pending_readings.push_back(typed ? want : r);
		if (f)
			ticks_sent++;
		else
			edges_sent++;
	endtask

	// register write, only once the block has drained
	task automatic write_reg(input logic [CFG_IDX_W-1:0] addr,
			input logic [CFG_DATA_W-1:0] data);
		in_valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (addr)
			REG_FAR_LIMIT:   cfg_m.far_limit   = data[DIST_W-1:0];
			REG_NEAR_LIMIT:  cfg_m.near_limit  = data[DIST_W-1:0];
			REG_VNEAR_LIMIT: cfg_m.vnear_limit = data[DIST_W-1:0];
			REG_FAR_BEEP:    cfg_m.far_beep    = data;
			REG_NEAR_BEEP:   cfg_m.near_beep   = data;
			REG_VNEAR_BEEP:  cfg_m.vnear_beep  = data;
			REG_GAP:         cfg_m.gap         = data;
			default: begin
				// unknown index, ignored by the block
			end
		endcase
	endtask

	// compare one result transfer against the oldest pending reading
	task automatic match_reading();
		reading_t want;
		reading_t got;
		got = '{distance_cm, zone_t'(zone), buzzer_on, red_pin, green_pin, blue_pin};
		readings_seen++;
		if (pending_readings.size() == 0) begin
			flag_mismatch("result transfer with nothing pending");
		end else begin
			want = pending_readings.pop_front();
			if (got.distance !== want.distance)
				flag_mismatch($sformatf("distance_cm %0d, wanted %0d",
					got.distance, want.distance));
			if (got.zone !== want.zone)
				flag_mismatch($sformatf("zone %0d, wanted %0d", got.zone, want.zone));
			if (got.buz !== want.buz)
				flag_mismatch($sformatf("buzzer_on %b, wanted %b", got.buz, want.buz));
			if (got.red !== want.red)
				flag_mismatch($sformatf("red_pin %b, wanted %b", got.red, want.red));
			if (got.green !== want.green)
				flag_mismatch($sformatf("green_pin %b, wanted %b", got.green, want.green));
			if (got.blue !== want.blue)
				flag_mismatch($sformatf("blue_pin %b, wanted %b", got.blue, want.blue));
		end
	endtask

	// receiver: checks transfers and drives out_ready with idle bursts and one long hold
	initial begin
		int hold;
		int stall_served;
		hold         = 0;
		stall_served = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				match_reading();
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else if (stall_served != stall_asked) begin
				// long hold-off while the sender keeps offering
				stall_served++;
				hold = LONG_HOLD - 1;
				out_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				hold = $urandom_range(0, 7);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// run limit
	initial begin
		#(RUN_LIMIT_NS);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int                    sent;
		int                    d;
		int                    drain;
		logic [STAMP_W-1:0]    rise;
		logic [STAMP_W-1:0]    width;
		logic [DIST_W-1:0]     lim_far;
		logic [DIST_W-1:0]     lim_near;
		logic [DIST_W-1:0]     lim_vnear;
		logic [MS_W-1:0]       dur[4];
		bit                    stalled;

		// every input known from time zero
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		func      <= 1'b0;
		edge_time <= '0;
		cfg_we    <= 1'b0;
		cfg_addr  <= '0;
		cfg_wdata <= '0;
		stalled   = 1'b0;

		// predictor reset state
		cfg_m       = CFG_RESET;
		want_rise_m = 1'b1;
		rise_m      = '0;
		dist_m      = '0;
		tone_m      = 1'b0;
		ms_m        = '0;
		zone_m      = ZONE_STOP;
		pins_m      = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: reset view, widest echo, zero gap, boundaries, misordered limits
		// first edge shows the reset state
		plan.push_back('{ROW_EDGE, '0, 16'hFFFF, 1'b1,
			'{9'd0, ZONE_STOP, 1'b0, 1'b0, 1'b0, 1'b0}});
		// falling stamp one below rising: width wraps to 65535
		plan.push_back('{ROW_EDGE, '0, 16'hFFFE, 1'b1,
			'{9'd376, ZONE_STOP, 1'b0, 1'b0, 1'b0, 1'b0}});
		plan.push_back('{ROW_WRITE, REG_FAR_BEEP, 16'd1, 1'b0, NO_CHECK});
		plan.push_back('{ROW_WRITE, REG_GAP, 16'd0, 1'b0, NO_CHECK});        // zero duration
		plan.push_back('{ROW_WRITE, REG_NEAR_BEEP, 16'd2, 1'b0, NO_CHECK});
		plan.push_back('{ROW_WRITE, REG_VNEAR_BEEP, 16'd1, 1'b0, NO_CHECK});
		// first tick starts a cycle, far zone
		plan.push_back('{ROW_TICK, '0, 16'hA5A5, 1'b1,
			'{9'd376, ZONE_FAR, 1'b1, 1'b1, 1'b1, 1'b0}});
		// one ms tone over, buzzer drops, leds stay
		plan.push_back('{ROW_TICK, '0, 16'h5A5A, 1'b1,
			'{9'd376, ZONE_FAR, 1'b0, 1'b1, 1'b1, 1'b0}});
		// zero gap ends on the next tick
		plan.push_back('{ROW_TICK, '0, 16'h0000, 1'b1,
			'{9'd376, ZONE_FAR, 1'b1, 1'b1, 1'b1, 1'b0}});
		plan.push_back('{ROW_EDGE, '0, 16'h0000, 1'b0, NO_CHECK});
		plan.push_back('{ROW_EDGE, '0, 16'h0DFC, 1'b0, NO_CHECK});   // 20 cm, near zone
		plan.push_back('{ROW_TICK, '0, 16'hFFFF, 1'b0, NO_CHECK});
		plan.push_back('{ROW_TICK, '0, 16'h1234, 1'b0, NO_CHECK});
		plan.push_back('{ROW_TICK, '0, 16'h8000, 1'b0, NO_CHECK});
		plan.push_back('{ROW_TICK, '0, 16'h7FFF, 1'b0, NO_CHECK});
		plan.push_back('{ROW_EDGE, '0, 16'h8000, 1'b0, NO_CHECK});
		plan.push_back('{ROW_EDGE, '0, 16'h8779, 1'b0, NO_CHECK});   // exactly 10 cm, stop
		plan.push_back('{ROW_TICK, '0, 16'h0001, 1'b0, NO_CHECK});
		plan.push_back('{ROW_TICK, '0, 16'h0002, 1'b0, NO_CHECK});
		plan.push_back('{ROW_TICK, '0, 16'h0003, 1'b0, NO_CHECK});
		plan.push_back('{ROW_WRITE, REG_UNUSED, 16'hFFFF, 1'b0, NO_CHECK});
		// reversed limits, cascade favors far
		plan.push_back('{ROW_WRITE, REG_FAR_LIMIT, 16'd0, 1'b0, NO_CHECK});
		plan.push_back('{ROW_WRITE, REG_NEAR_LIMIT, 16'd511, 1'b0, NO_CHECK});
		plan.push_back('{ROW_WRITE, REG_VNEAR_LIMIT, 16'd511, 1'b0, NO_CHECK});
		plan.push_back('{ROW_EDGE, '0, 16'h5555, 1'b0, NO_CHECK});   // zero width echo
		plan.push_back('{ROW_EDGE, '0, 16'h5555, 1'b0, NO_CHECK});
		plan.push_back('{ROW_TICK, '0, 16'hC3C3, 1'b0, NO_CHECK});
		plan.push_back('{ROW_TICK, '0, 16'h3C3C, 1'b0, NO_CHECK});
		plan.push_back('{ROW_EDGE, '0, 16'hAAAA, 1'b0, NO_CHECK});
		plan.push_back('{ROW_EDGE, '0, 16'hAB58, 1'b0, NO_CHECK});   // 1 cm, above far limit 0
		plan.push_back('{ROW_TICK, '0, 16'hF00F, 1'b0, NO_CHECK});
		plan.push_back('{ROW_TICK, '0, 16'h0FF0, 1'b0, NO_CHECK});
		plan.push_back('{ROW_TICK, '0, 16'h9999, 1'b0, NO_CHECK});

		foreach (plan[i]) begin
			case (plan[i].kind)
				ROW_WRITE: write_reg(plan[i].addr, plan[i].value);
				ROW_EDGE:  push_item(1'b0, plan[i].value, plan[i].typed, plan[i].want);
				default:   push_item(1'b1, plan[i].value, plan[i].typed, plan[i].want);
			endcase
		end
		settings_used = 2;

		// random phases, each with its own register setting
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			// last phase runs without idling on either side
			idle_on = (phase != NUM_PHASES - 1);

			lim_vnear = 9'($urandom_range(0, 120));
			lim_near  = lim_vnear + 9'($urandom_range(0, 120));
			lim_far   = lim_near + 9'($urandom_range(0, 150));
			for (int k = 0; k < 4; k++)
				dur[k] = 16'($urandom_range(1, 4));
			case (phase)
				1: begin
					for (int k = 0; k < 4; k++)
						dur[k] = 16'($urandom_range(0, 3));   // zero durations too
				end
				2: begin
					// misordered limits
					lim_far   = 9'($urandom_range(0, 511));
					lim_near  = 9'($urandom_range(0, 511));
					lim_vnear = 9'($urandom_range(0, 511));
					for (int k = 0; k < 4; k++)
						dur[k] = 16'($urandom_range(1, 6));
				end
				3: begin
					// top limits, every distance lands in stop
					lim_far   = DIST_MAX;
					lim_near  = DIST_MAX;
					lim_vnear = DIST_MAX;
				end
				4: begin
					// bottom limits and longest far tone and gap
					lim_far   = '0;
					lim_near  = '0;
					lim_vnear = '0;
					dur[0]    = 16'hFFFF;
					dur[3]    = 16'hFFFF;
				end
				5: begin
					// random wide duration on the near window, short very near window
					dur[1] = 16'($urandom);
					dur[2] = 16'($urandom_range(1, 2));
				end
				default: begin
				end
			endcase
			// limit writes carry random upper bits that the block drops
			write_reg(REG_FAR_LIMIT, {7'($urandom), lim_far});
			write_reg(REG_NEAR_LIMIT, {7'($urandom), lim_near});
			write_reg(REG_VNEAR_LIMIT, {7'($urandom), lim_vnear});
			write_reg(REG_FAR_BEEP, dur[0]);
			write_reg(REG_NEAR_BEEP, dur[1]);
			write_reg(REG_VNEAR_BEEP, dur[2]);
			write_reg(REG_GAP, dur[3]);
			if (phase == 6)
				write_reg(REG_UNUSED, 16'($urandom));
			settings_used++;

			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if (phase == 1 && sent >= 20 && !stalled) begin
					stall_asked++;
					stalled = 1'b1;
				end
				case ($urandom_range(0, 9))
					0, 1, 2: begin
						// echo pair aimed at one of the zone limits
						case ($urandom_range(0, 2))
							0:       d = int'(cfg_m.far_limit);
							1:       d = int'(cfg_m.near_limit);
							default: d = int'(cfg_m.vnear_limit);
						endcase
						d = d + int'($urandom_range(0, 2)) - 1;
						if (d < 0)
							d = 0;
						if (d > 375 || $urandom_range(0, 7) == 0)
							width = 16'($urandom);
						else
							width = 16'(d * CM_PER_WIDTH + int'($urandom_range(0, 173)));
						rise = 16'($urandom);
						push_item(1'b0, rise, 1'b0, NO_CHECK);
						sent++;
						// now and then the falling edge goes missing
						if ($urandom_range(0, 9) != 0) begin
							push_item(1'b0, rise + width, 1'b0, NO_CHECK);
							sent++;
						end
					end
					3: begin
						// stray edge with a random stamp
						push_item(1'b0, 16'($urandom), 1'b0, NO_CHECK);
						sent++;
					end
					default: begin
						repeat ($urandom_range(1, 4)) begin
							push_item(1'b1, 16'($urandom), 1'b0, NO_CHECK);
							sent++;
						end
					end
				endcase
			end
		end

		// drain what is still in flight
		in_valid <= 1'b0;
		drain = 0;
		while (pending_readings.size() != 0 && drain < 2000) begin
			@(posedge clk);
			drain++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_readings.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", pending_readings.size()));

		$display("run covered %0d edge and %0d tick transfers, %0d results checked",
			edges_sent, ticks_sent, readings_seen);
		$display("across %0d register settings, %0d mismatches", settings_used, mismatch_count);
		if (mismatch_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
